// File: rtl/dcbbd_pkg.sv
// Shared types, memory sizes, address map constants and region decoder.
`default_nettype none
package dcbbd_pkg;

    // Memory sizes
    localparam int PALETTE_WORDS    = 4096;
    localparam int LOCAL_RAM_BYTES  = 16384;
    localparam int SHARED_RAM_BYTES = 16384;
    localparam int TILE_RAM_BYTES   = 65536;
    localparam int ROAD_RAM_BYTES   = 8192;
    localparam int SPRITE_RAM_BYTES = 1792;
    localparam int TILE_CTRL_BYTES  = 16;

    localparam int LOCAL_AW  = $clog2(LOCAL_RAM_BYTES);
    localparam int SHARED_AW = $clog2(SHARED_RAM_BYTES);
    localparam int TILE_AW   = $clog2(TILE_RAM_BYTES);
    localparam int ROAD_AW   = $clog2(ROAD_RAM_BYTES);
    localparam int SPRITE_AW = $clog2(SPRITE_RAM_BYTES);
    localparam int TCTL_AW   = $clog2(TILE_CTRL_BYTES);
    localparam int PAL_AW    = $clog2(PALETTE_WORDS);

    // Address map
    localparam logic [23:0] ROM_END        = 24'h040000;
    localparam logic [23:0] MAIN_PRIV_BASE = 24'h080000;
    localparam logic [23:0] SHARED_BASE    = 24'h084000;
    localparam logic [23:0] BANK_ADDR      = 24'h090001;
    localparam logic [23:0] PAL_PORT_BASE  = 24'h100000;
    localparam logic [23:0] PORT_DATA_ADDR = 24'h100001;
    localparam logic [23:0] PORT_SEL_ADDR  = 24'h100003;
    localparam logic [23:0] TILE_BASE      = 24'h200000;
    localparam logic [23:0] SUB_ZERO_ADDR  = 24'h200003;
    localparam logic [23:0] TCTL_BASE      = 24'h220000;
    localparam logic [23:0] TCTL_LAST      = 24'h220010 - 24'd1;
    localparam logic [23:0] ROAD_BASE      = 24'h300000;
    localparam logic [23:0] SPRITE_BASE    = 24'h400000;
    localparam logic [23:0] SPRITE_END     = 24'h400700;
    localparam logic [23:0] ROAD_END       = 24'h302000;

    localparam logic [7:0] BANK_MASK    = 8'hc0;
    localparam logic [7:0] UNMAPPED_VAL = 8'hff;

    // Palette port word select
    localparam logic [1:0] PAL_WORD_ADDR = 2'd0;
    localparam logic [1:0] PAL_WORD_DATA = 2'd1;

    // Configuration register indexes
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;
    localparam logic [CFG_IW-1:0] CFG_DIP_A    = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_DIP_B    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_INPUT_0  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_INPUT_1  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_INPUT_2  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_STEERING = 3'd5;

    localparam logic [7:0] DIP_A_RESET   = 8'hff;
    localparam logic [7:0] DIP_B_RESET   = 8'hcf;
    localparam logic [7:0] INPUT_0_RESET = 8'h13;
    localparam logic [7:0] INPUT_1_RESET = 8'h1f;
    localparam logic [7:0] INPUT_2_RESET = 8'hff;

    // Input port select values
    localparam logic [7:0] PSEL_DIP_A   = 8'd0;
    localparam logic [7:0] PSEL_DIP_B   = 8'd1;
    localparam logic [7:0] PSEL_INPUT_0 = 8'd2;
    localparam logic [7:0] PSEL_INPUT_1 = 8'd3;
    localparam logic [7:0] PSEL_LATCHED = 8'd4;
    localparam logic [7:0] PSEL_INPUT_2 = 8'd7;
    localparam logic [7:0] PSEL_STEER_L = 8'd8;
    localparam logic [7:0] PSEL_STEER_H = 8'd9;
    localparam logic [2:0] LATCHED_PORT = 3'd4;

    // Decoded regions
    typedef logic [3:0] region_t;
    localparam region_t RG_UNMAPPED  = 4'd0;
    localparam region_t RG_ROM       = 4'd1;
    localparam region_t RG_PRIV      = 4'd2;
    localparam region_t RG_SHARED    = 4'd3;
    localparam region_t RG_TILE      = 4'd4;
    localparam region_t RG_TCTL      = 4'd5;
    localparam region_t RG_ROAD      = 4'd6;
    localparam region_t RG_SPRITE    = 4'd7;
    localparam region_t RG_PAL_DATA  = 4'd8;
    localparam region_t RG_PAL_ADDR  = 4'd9;
    localparam region_t RG_PAL_IDLE  = 4'd10;
    localparam region_t RG_BANK      = 4'd11;
    localparam region_t RG_PORT_DATA = 4'd12;
    localparam region_t RG_PORT_SEL  = 4'd13;
    localparam region_t RG_SUB_ZERO  = 4'd14;

    // Register-side request of one accepted transfer
    typedef struct packed {
        logic       fire;
        logic       wr;
        region_t    region;
        logic       addr0;
        logic [7:0] wdata;
    } io_req_t;

    function automatic region_t decode_region(input logic is_sub, input logic [23:0] a);
        region_t r;
        r = RG_UNMAPPED;
        if (a < ROM_END) begin
            r = RG_ROM;
        end else if (a >= MAIN_PRIV_BASE && a < SHARED_BASE) begin
            r = RG_PRIV;
        end else if (a >= SHARED_BASE && a < SHARED_BASE + 24'(SHARED_RAM_BYTES)) begin
            r = RG_SHARED;
        end else if (is_sub) begin
            if (a == PORT_DATA_ADDR)
                r = RG_PORT_DATA;
            else if (a == PORT_SEL_ADDR)
                r = RG_PORT_SEL;
            else if (a == SUB_ZERO_ADDR)
                r = RG_SUB_ZERO;
        end else begin
            if (a == BANK_ADDR) begin
                r = RG_BANK;
            end else if (a[23:3] == PAL_PORT_BASE[23:3]) begin
                if (a[2:1] == PAL_WORD_ADDR)
                    r = RG_PAL_ADDR;
                else if (a[2:1] == PAL_WORD_DATA)
                    r = RG_PAL_DATA;
                else
                    r = RG_PAL_IDLE;
            end else if (a >= TILE_BASE && a < TILE_BASE + 24'(TILE_RAM_BYTES)) begin
                r = RG_TILE;
            end else if (a >= TCTL_BASE && a <= TCTL_LAST) begin
                r = RG_TCTL;
            end else if (a >= ROAD_BASE && a < ROAD_END) begin
                r = RG_ROAD;
            end else if (a >= SPRITE_BASE && a < SPRITE_END) begin
                r = RG_SPRITE;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/dcbbd_ram.sv
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module dcbbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           en,
    input  wire logic                           we,
    input  wire logic [$clog2(DEPTH)-1:0]       addr,
    input  wire logic [WIDTH-1:0]               wdata,
    output logic      [WIDTH-1:0]               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/dcbbd_io.sv
// Configuration registers, input chip, palette address latch and road bank latch.
`default_nettype none
module dcbbd_io (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_fire,
    input  wire logic [dcbbd_pkg::CFG_IW-1:0]    cfg_index,
    input  wire logic [dcbbd_pkg::CFG_DW-1:0]    cfg_data,
    input  wire dcbbd_pkg::io_req_t              req,
    output logic      [7:0]                      port_byte,
    output logic      [dcbbd_pkg::PAL_AW-1:0]    pal_index,
    output logic      [1:0]                      bank
);
    import dcbbd_pkg::*;

    logic [7:0]  dip_a_reg, dip_a_next;
    logic [7:0]  dip_b_reg, dip_b_next;
    logic [7:0]  input0_reg, input0_next;
    logic [7:0]  input1_reg, input1_next;
    logic [7:0]  input2_reg, input2_next;
    logic [15:0] steer_reg, steer_next;
    logic [15:0] pal_latch_reg, pal_latch_next;
    logic [1:0]  bank_reg, bank_next;
    logic [7:0]  psel_reg, psel_next;
    logic [7:0]  port_regs_reg [8];
    logic [7:0]  port_regs_next [8];
    logic        wr_fire;

    assign wr_fire = req.fire && req.wr;

    always_comb begin
        dip_a_next  = dip_a_reg;
        dip_b_next  = dip_b_reg;
        input0_next = input0_reg;
        input1_next = input1_reg;
        input2_next = input2_reg;
        steer_next  = steer_reg;
        if (cfg_fire) begin
            case (cfg_index)
                CFG_DIP_A:    dip_a_next  = cfg_data[7:0];
                CFG_DIP_B:    dip_b_next  = cfg_data[7:0];
                CFG_INPUT_0:  input0_next = cfg_data[7:0];
                CFG_INPUT_1:  input1_next = cfg_data[7:0];
                CFG_INPUT_2:  input2_next = cfg_data[7:0];
                CFG_STEERING: steer_next  = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        pal_latch_next = pal_latch_reg;
        bank_next      = bank_reg;
        psel_next      = psel_reg;
        port_regs_next = port_regs_reg;
        if (wr_fire) begin
            case (req.region)
                RG_PAL_ADDR: begin
                    if (req.addr0)
                        pal_latch_next[7:0] = req.wdata;
                    else
                        pal_latch_next[15:8] = req.wdata;
                end
                RG_BANK:      bank_next = 2'((req.wdata & BANK_MASK) >> 6);
                RG_PORT_SEL:  psel_next = req.wdata;
                RG_PORT_DATA: port_regs_next[psel_reg[2:0]] = req.wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dip_a_reg     <= DIP_A_RESET;
            dip_b_reg     <= DIP_B_RESET;
            input0_reg    <= INPUT_0_RESET;
            input1_reg    <= INPUT_1_RESET;
            input2_reg    <= INPUT_2_RESET;
            steer_reg     <= '0;
            pal_latch_reg <= '0;
            bank_reg      <= '0;
            psel_reg      <= '0;
            for (int i = 0; i < 8; i++)
                port_regs_reg[i] <= '0;
        end else begin
            dip_a_reg     <= dip_a_next;
            dip_b_reg     <= dip_b_next;
            input0_reg    <= input0_next;
            input1_reg    <= input1_next;
            input2_reg    <= input2_next;
            steer_reg     <= steer_next;
            pal_latch_reg <= pal_latch_next;
            bank_reg      <= bank_next;
            psel_reg      <= psel_next;
            port_regs_reg <= port_regs_next;
        end
    end

    always_comb begin
        case (psel_reg)
            PSEL_DIP_A:   port_byte = dip_a_reg;
            PSEL_DIP_B:   port_byte = dip_b_reg;
            PSEL_INPUT_0: port_byte = input0_reg;
            PSEL_INPUT_1: port_byte = input1_reg;
            PSEL_LATCHED: port_byte = port_regs_reg[LATCHED_PORT];
            PSEL_INPUT_2: port_byte = input2_reg;
            PSEL_STEER_L: port_byte = steer_reg[7:0];
            PSEL_STEER_H: port_byte = steer_reg[15:8];
            default:      port_byte = UNMAPPED_VAL;
        endcase
    end

    assign pal_index = pal_latch_reg[PAL_AW-1:0];
    assign bank      = bank_reg;

endmodule
`default_nettype wire

// File: rtl/dual_cpu_board_bus_decoder_top.sv
// Top level: two-processor bus decoder with RAM banks, palette port and input chip.
// An accepted transfer addresses the RAMs at the accept edge; in ST_DONE their registered
// read data is steered into the output register once that register is free.
// A new access is not accepted until the result of the last one has been loaded.
// The output register lets the next access be accepted while a result waits.
// Reset: synchronous active-low aresetn clears latches, port registers and
// handshake state; RAM contents are not cleared and must be written before read.
`default_nettype none
module dual_cpu_board_bus_decoder_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // access channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,  // address[23:0], write_byte[31:24]
    input  wire logic [1:0]                    s_tuser,  // cmd[0], cpu_select[1]
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [15:0]                   m_tdata,  // read_byte[7:0], road_palette_bank[9:8], zero pad
    output logic                               m_tuser,  // rom_hit[0]
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dcbbd_pkg::CFG_IW-1:0]  cfg_index,
    input  wire logic [dcbbd_pkg::CFG_DW-1:0]  cfg_data
);
    import dcbbd_pkg::*;

    localparam logic ST_IDLE = 1'b0;  // ready for an access
    localparam logic ST_DONE = 1'b1;  // RAM data out, form the result

    logic        state_reg, state_next;
    logic        wr_reg, wr_next;
    logic        cpu_reg, cpu_next;
    logic        addr0_reg, addr0_next;
    region_t     region_reg, region_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_byte_reg, m_byte_next;
    logic [1:0]  m_bank_reg, m_bank_next;
    logic        m_rom_reg, m_rom_next;

    logic        s_fire;
    logic        in_wr;
    logic        in_sub;
    logic [23:0] in_addr;
    logic [7:0]  in_byte;
    region_t     in_region;
    io_req_t     io_req;
    logic        load_out;

    logic [7:0]        port_byte;
    logic [PAL_AW-1:0] pal_index;
    logic [1:0]        bank;

    logic [7:0] main_q, sub_q, shared_q, tile_q, tctl_q, road_q, sprite_q, pal_hi_q, pal_lo_q;
    logic en_main, en_sub, en_shared, en_tile, en_tctl, en_road, en_sprite, en_pal_hi, en_pal_lo;

    assign in_wr   = s_tuser[0];
    assign in_sub  = s_tuser[1];
    assign in_addr = s_tdata[23:0];
    assign in_byte = s_tdata[31:24];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign in_region = decode_region(in_sub, in_addr);

    // Latches and port registers update at the accept edge.
    assign io_req.fire   = s_fire;
    assign io_req.wr     = in_wr;
    assign io_req.region = in_region;
    assign io_req.addr0  = in_addr[0];
    assign io_req.wdata  = in_byte;

    dcbbd_io u_io (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (io_req),
        .port_byte (port_byte),
        .pal_index (pal_index),
        .bank      (bank)
    );

    // RAM strobes: one access per transfer, so no two accesses to an entry overlap.
    assign en_main   = s_fire && (in_region == RG_PRIV) && !in_sub;
    assign en_sub    = s_fire && (in_region == RG_PRIV) && in_sub;
    assign en_shared = s_fire && (in_region == RG_SHARED);
    assign en_tile   = s_fire && (in_region == RG_TILE);
    assign en_tctl   = s_fire && (in_region == RG_TCTL);
    assign en_road   = s_fire && (in_region == RG_ROAD);
    assign en_sprite = s_fire && (in_region == RG_SPRITE);
    // Palette words are kept as two byte lanes; only the addressed lane is touched.
    assign en_pal_hi = s_fire && (in_region == RG_PAL_DATA) && !in_addr[0];
    assign en_pal_lo = s_fire && (in_region == RG_PAL_DATA) && in_addr[0];

    dcbbd_ram #(.WIDTH(8), .DEPTH(LOCAL_RAM_BYTES)) u_main_ram (
        .aclk(aclk), .en(en_main), .we(in_wr), .addr(in_addr[LOCAL_AW-1:0]),
        .wdata(in_byte), .rdata(main_q)
    );
    dcbbd_ram #(.WIDTH(8), .DEPTH(LOCAL_RAM_BYTES)) u_sub_ram (
        .aclk(aclk), .en(en_sub), .we(in_wr), .addr(in_addr[LOCAL_AW-1:0]),
        .wdata(in_byte), .rdata(sub_q)
    );
    dcbbd_ram #(.WIDTH(8), .DEPTH(SHARED_RAM_BYTES)) u_shared_ram (
        .aclk(aclk), .en(en_shared), .we(in_wr), .addr(in_addr[SHARED_AW-1:0]),
        .wdata(in_byte), .rdata(shared_q)
    );
    dcbbd_ram #(.WIDTH(8), .DEPTH(TILE_RAM_BYTES)) u_tile_ram (
        .aclk(aclk), .en(en_tile), .we(in_wr), .addr(in_addr[TILE_AW-1:0]),
        .wdata(in_byte), .rdata(tile_q)
    );
    dcbbd_ram #(.WIDTH(8), .DEPTH(TILE_CTRL_BYTES)) u_tctl_ram (
        .aclk(aclk), .en(en_tctl), .we(in_wr), .addr(in_addr[TCTL_AW-1:0]),
        .wdata(in_byte), .rdata(tctl_q)
    );
    dcbbd_ram #(.WIDTH(8), .DEPTH(ROAD_RAM_BYTES)) u_road_ram (
        .aclk(aclk), .en(en_road), .we(in_wr), .addr(in_addr[ROAD_AW-1:0]),
        .wdata(in_byte), .rdata(road_q)
    );
    dcbbd_ram #(.WIDTH(8), .DEPTH(SPRITE_RAM_BYTES)) u_sprite_ram (
        .aclk(aclk), .en(en_sprite), .we(in_wr), .addr(in_addr[SPRITE_AW-1:0]),
        .wdata(in_byte), .rdata(sprite_q)
    );
    dcbbd_ram #(.WIDTH(8), .DEPTH(PALETTE_WORDS)) u_pal_hi_ram (
        .aclk(aclk), .en(en_pal_hi), .we(in_wr), .addr(pal_index),
        .wdata(in_byte), .rdata(pal_hi_q)
    );
    dcbbd_ram #(.WIDTH(8), .DEPTH(PALETTE_WORDS)) u_pal_lo_ram (
        .aclk(aclk), .en(en_pal_lo), .we(in_wr), .addr(pal_index),
        .wdata(in_byte), .rdata(pal_lo_q)
    );

    // Access bookkeeping for the result stage.
    always_comb begin
        wr_next     = wr_reg;
        cpu_next    = cpu_reg;
        addr0_next  = addr0_reg;
        region_next = region_reg;
        if (s_fire) begin
            wr_next     = in_wr;
            cpu_next    = in_sub;
            addr0_next  = in_addr[0];
            region_next = in_region;
        end
    end

    // Result stage waits in ST_DONE while the output register is held.
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_DONE;
            ST_DONE: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_byte_next = UNMAPPED_VAL;
        m_rom_next  = 1'b0;
        if (wr_reg) begin
            m_byte_next = '0;
        end else begin
            case (region_reg)
                RG_ROM: begin
                    m_byte_next = '0;
                    m_rom_next  = 1'b1;
                end
                RG_PRIV:      m_byte_next = cpu_reg ? sub_q : main_q;
                RG_SHARED:    m_byte_next = shared_q;
                RG_TILE:      m_byte_next = tile_q;
                RG_TCTL:      m_byte_next = tctl_q;
                RG_ROAD:      m_byte_next = road_q;
                RG_SPRITE:    m_byte_next = sprite_q;
                RG_PAL_DATA:  m_byte_next = addr0_reg ? pal_lo_q : pal_hi_q;
                RG_PORT_DATA: m_byte_next = port_byte;
                RG_PAL_ADDR,
                RG_PAL_IDLE,
                RG_PORT_SEL,
                RG_SUB_ZERO:  m_byte_next = '0;
                default:      m_byte_next = UNMAPPED_VAL;  // unmapped, incl. bank latch reads
            endcase
        end
        // bank latch already reflects this access
        m_bank_next = bank;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_reg     <= wr_next;
        cpu_reg    <= cpu_next;
        addr0_reg  <= addr0_next;
        region_reg <= region_next;
        if (load_out) begin
            m_byte_reg <= m_byte_next;
            m_bank_reg <= m_bank_next;
            m_rom_reg  <= m_rom_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_bank_reg, m_byte_reg};
    assign m_tuser  = m_rom_reg;

endmodule
`default_nettype wire
